// File: rtl/core/clas_pkg.sv
// shared types and constants for the command line argument splitter
package clas_pkg;

    // byte classes handed from the front to the back
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_BLANK,
        CLS_BSLASH,
        CLS_DQUOTE,
        CLS_SQUOTE,
        CLS_END
    } cls_t;

    // one classified word in the queue
    typedef struct packed {
        cls_t       cls;
        logic [7:0] ch;
    } word_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // widths of the result fields
    localparam int FIELD_BITS = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

endpackage

// File: rtl/core/clas_front.sv
// front stage: accepts input words and classifies each byte
module clas_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     char_in,
    input  logic           end_of_text,
    input  logic           in_valid,
    output logic           in_stall,
    output clas_pkg::word_t q_word,
    output logic           q_valid,
    input  logic           q_stall
);
    import clas_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    word_t word_reg;
    word_t word_next;

    // hold while a classified word waits on a full queue
    assign in_stall = vld_reg && q_stall;

    // classify the incoming byte
    always_comb
    begin
        word_next.ch = char_in;
        if (end_of_text)
        begin
            word_next.cls = CLS_END;
        end
        else if (char_in == CH_SPACE || char_in inside {[CH_TAB:CH_CR]})
        begin
            word_next.cls = CLS_BLANK;
        end
        else if (char_in == CH_BSLASH)
        begin
            word_next.cls = CLS_BSLASH;
        end
        else if (char_in == CH_DQUOTE)
        begin
            word_next.cls = CLS_DQUOTE;
        end
        else if (char_in == CH_SQUOTE)
        begin
            word_next.cls = CLS_SQUOTE;
        end
        else
        begin
            word_next.cls = CLS_OTHER;
        end
    end

    assign vld_next = in_stall ? vld_reg : in_valid;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // classified word register
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            word_reg <= word_next;
        end
    end

    assign q_word  = word_reg;
    assign q_valid = vld_reg;

endmodule

// File: rtl/core/clas_queue.sv
// short first-word-fall-through queue between front and back
module clas_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  clas_pkg::word_t push_word,
    input  logic            push_valid,
    output logic            push_stall,
    output clas_pkg::word_t pop_word,
    output logic            pop_valid,
    input  logic            pop_stall
);
    import clas_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    word_t         mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          push;
    logic          pop;

    assign push_stall = (cnt_reg == FULL_COUNT);
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;
    assign pop_word   = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_COUNT)
        else $error("queue fill count above depth");

    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("queue count missed a push");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == FULL_COUNT) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill count");

endmodule

// File: rtl/core/clas_back.sv
// back stage: quote and backslash state machine with output register
module clas_back #(
    parameter int SLASH_COUNT_BITS = 16,
    parameter int ARG_COUNT_BITS   = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  clas_pkg::word_t q_word,
    input  logic            q_valid,
    output logic            q_stall,
    output logic [15:0]     backslash_repeat,
    output logic [7:0]      char_out,
    output logic            char_valid,
    output logic            arg_begin,
    output logic            arg_end,
    output logic            line_done,
    output logic            parse_error,
    output logic [15:0]     arg_total,
    output logic            out_valid,
    input  logic            out_stall
);
    import clas_pkg::*;

    localparam int SW = (SLASH_COUNT_BITS >= FIELD_BITS) ? FIELD_BITS : SLASH_COUNT_BITS;
    localparam int AW = (ARG_COUNT_BITS >= FIELD_BITS) ? FIELD_BITS : ARG_COUNT_BITS;

    typedef enum logic [1:0] {
        QM_NONE,
        QM_DOUBLE,
        QM_SINGLE
    } qmode_t;

    // line state
    qmode_t          qm_reg;
    qmode_t          qm_next;
    logic            ins_reg;
    logic            ins_next;
    logic [SW-1:0]   pend_reg;
    logic [SW-1:0]   pend_next;
    logic [AW-1:0]   cnt_reg;
    logic [AW-1:0]   cnt_next;
    logic            ovf_reg;
    logic            ovf_next;

    // output word
    logic            out_vld_reg;
    logic [15:0]     rep_reg;
    logic [15:0]     rep_next;
    logic [7:0]      ch_reg;
    logic [7:0]      ch_next;
    logic            cv_reg;
    logic            cv_next;
    logic            beg_reg;
    logic            beg_next;
    logic            end_reg;
    logic            end_next;
    logic            done_reg;
    logic            done_next;
    logic            err_reg;
    logic            err_next;
    logic [15:0]     tot_reg;
    logic [15:0]     tot_next;

    logic            take;
    logic            literal;
    qmode_t          kind;

    // a held result blocks the queue only while it is stalled
    assign q_stall = out_vld_reg && out_stall;
    assign take    = q_valid && !q_stall;

    // one byte of parsing
    always_comb
    begin
        qm_next   = qm_reg;
        ins_next  = ins_reg;
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        rep_next  = '0;
        ch_next   = '0;
        cv_next   = 1'b0;
        beg_next  = 1'b0;
        end_next  = 1'b0;
        done_next = 1'b0;
        err_next  = 1'b0;
        tot_next  = '0;
        literal   = 1'b0;
        kind      = (q_word.cls == CLS_DQUOTE) ? QM_DOUBLE : QM_SINGLE;

        if (q_word.cls == CLS_END)
        begin
            // end of line: report and return to reset state
            err_next  = ovf_reg || (qm_reg != QM_NONE);
            tot_next  = err_next ? '0 : 16'(cnt_reg);
            rep_next  = 16'(pend_reg);
            end_next  = ins_reg;
            done_next = 1'b1;
            qm_next   = QM_NONE;
            ins_next  = 1'b0;
            pend_next = '0;
            cnt_next  = '0;
            ovf_next  = 1'b0;
        end
        else if (!ins_reg && q_word.cls == CLS_BLANK)
        begin
            // whitespace between arguments gives an empty result
        end
        else
        begin
            // open an argument
            if (!ins_reg)
            begin
                beg_next = 1'b1;
                ins_next = 1'b1;
                if (&cnt_reg)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            if (q_word.cls == CLS_BSLASH && qm_reg != QM_SINGLE)
            begin
                // extend the backslash run
                if (&pend_reg)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    pend_next = pend_reg + SW'(1);
                end
            end
            else
            begin
                pend_next = '0;
                rep_next  = 16'(pend_reg);
                if (q_word.cls == CLS_DQUOTE && pend_reg != '0)
                begin
                    rep_next = 16'(pend_reg >> 1);
                    literal  = pend_reg[0];
                end

                if (literal)
                begin
                    cv_next = 1'b1;
                    ch_next = q_word.ch;
                end
                else if (qm_reg == QM_NONE && q_word.cls == CLS_BLANK)
                begin
                    ins_next = 1'b0;
                    end_next = 1'b1;
                end
                else if ((q_word.cls == CLS_DQUOTE || q_word.cls == CLS_SQUOTE)
                         && (qm_reg == QM_NONE || qm_reg == kind))
                begin
                    // quote opens or closes and is dropped
                    qm_next = (qm_reg == QM_NONE) ? kind : QM_NONE;
                end
                else
                begin
                    cv_next = 1'b1;
                    ch_next = q_word.ch;
                end
            end
        end
    end

    // line state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qm_reg      <= QM_NONE;
            ins_reg     <= 1'b0;
            pend_reg    <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                qm_reg   <= qm_next;
                ins_reg  <= ins_next;
                pend_reg <= pend_next;
                cnt_reg  <= cnt_next;
                ovf_reg  <= ovf_next;
            end
            if (!q_stall)
            begin
                out_vld_reg <= q_valid;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rep_reg  <= rep_next;
            ch_reg   <= ch_next;
            cv_reg   <= cv_next;
            beg_reg  <= beg_next;
            end_reg  <= end_next;
            done_reg <= done_next;
            err_reg  <= err_next;
            tot_reg  <= tot_next;
        end
    end

    assign backslash_repeat = rep_reg;
    assign char_out         = ch_reg;
    assign char_valid       = cv_reg;
    assign arg_begin        = beg_reg;
    assign arg_end          = end_reg;
    assign line_done        = done_reg;
    assign parse_error      = err_reg;
    assign arg_total        = tot_reg;
    assign out_valid        = out_vld_reg;

    a_err_total: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && err_reg) |-> (done_reg && tot_reg == '0))
        else $error("error word carries an argument total");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (take && q_word.cls == CLS_END) |=>
            (qm_reg == QM_NONE && !ins_reg && pend_reg == '0 && cnt_reg == '0 && !ovf_reg))
        else $error("line state not cleared after end of text");

    a_take_out: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_vld_reg)
        else $error("taken word produced no result");

endmodule

// File: rtl/core/command_line_argument_splitter.sv
// Command line argument splitter: one byte word in, one result word out. A byte
// first goes through the classifying front register, then a four-word queue, then
// the parse state machine in the back, which registers the result. Sustained rate
// is one byte per clock while the output is not stalled. Either side may stall on
// its own: the queue absorbs up to four words while the output is held. Counters
// saturate at 2^bits-1 (at most 65535); an overflow or an open quote makes the
// end-of-text result report parse_error with arg_total zero.
module command_line_argument_splitter #(
    parameter int SLASH_COUNT_BITS = 16,
    parameter int ARG_COUNT_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_in,
    input  logic        end_of_text,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [15:0] backslash_repeat,
    output logic [7:0]  char_out,
    output logic        char_valid,
    output logic        arg_begin,
    output logic        arg_end,
    output logic        line_done,
    output logic        parse_error,
    output logic [15:0] arg_total,
    output logic        out_valid,
    input  logic        out_stall
);
    import clas_pkg::*;

    word_t f_word;
    logic  f_valid;
    logic  f_stall;
    word_t b_word;
    logic  b_valid;
    logic  b_stall;

    // classify
    clas_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_in     (char_in),
        .end_of_text (end_of_text),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .q_word      (f_word),
        .q_valid     (f_valid),
        .q_stall     (f_stall)
    );

    // decouple
    clas_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_word  (f_word),
        .push_valid (f_valid),
        .push_stall (f_stall),
        .pop_word   (b_word),
        .pop_valid  (b_valid),
        .pop_stall  (b_stall)
    );

    // parse
    clas_back #(
        .SLASH_COUNT_BITS (SLASH_COUNT_BITS),
        .ARG_COUNT_BITS   (ARG_COUNT_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_word           (b_word),
        .q_valid          (b_valid),
        .q_stall          (b_stall),
        .backslash_repeat (backslash_repeat),
        .char_out         (char_out),
        .char_valid       (char_valid),
        .arg_begin        (arg_begin),
        .arg_end          (arg_end),
        .line_done        (line_done),
        .parse_error      (parse_error),
        .arg_total        (arg_total),
        .out_valid        (out_valid),
        .out_stall        (out_stall)
    );

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the command line argument splitter
`timescale 1ns / 1ps

module tb_top;
    import clas_pkg::*;

    localparam int SLASH_COUNT_BITS = 16;
    localparam int ARG_COUNT_BITS   = 16;
    localparam int SLASH_LIMIT = (SLASH_COUNT_BITS >= 16) ? 65535 : (1 << SLASH_COUNT_BITS) - 1;
    localparam int ARG_LIMIT   = (ARG_COUNT_BITS >= 16) ? 65535 : (1 << ARG_COUNT_BITS) - 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [1:0] {
        QUOTE_NONE,
        QUOTE_DOUBLE,
        QUOTE_SINGLE
    } quote_t;

    // one result word as the splitter reports it
    typedef struct packed {
        logic [15:0] backslash_repeat;
        logic [7:0]  char_out;
        logic        char_valid;
        logic        arg_begin;
        logic        arg_end;
        logic        line_done;
        logic        parse_error;
        logic [15:0] arg_total;
    } split_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  char_in = 8'h00;
    logic        end_of_text = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] backslash_repeat;
    logic [7:0]  char_out;
    logic        char_valid;
    logic        arg_begin;
    logic        arg_end;
    logic        line_done;
    logic        parse_error;
    logic [15:0] arg_total;
    logic        out_valid;
    logic        out_stall = 1'b0;

    // predictor copy of the splitter state
    quote_t quote_state = QUOTE_NONE;
    logic   in_argument = 1'b0;
    int     backslash_run = 0;
    int     args_opened = 0;
    logic   count_overflow = 1'b0;

    split_result_t expected_splits[$];

    // shared control and run statistics
    logic idle_on = 1'b0;
    int   hold_req = 0;
    int   longest_hold = 0;
    int   cycles = 0;
    int   mismatches = 0;
    int   words_sent = 0;
    int   lines_sent = 0;
    int   lines_rejected = 0;
    int   results_checked = 0;
    int   input_stall_cycles = 0;

    command_line_argument_splitter #(
        .SLASH_COUNT_BITS(SLASH_COUNT_BITS),
        .ARG_COUNT_BITS  (ARG_COUNT_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_in         (char_in),
        .end_of_text     (end_of_text),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .backslash_repeat(backslash_repeat),
        .char_out        (char_out),
        .char_valid      (char_valid),
        .arg_begin       (arg_begin),
        .arg_end         (arg_end),
        .line_done       (line_done),
        .parse_error     (parse_error),
        .arg_total       (arg_total),
        .out_valid       (out_valid),
        .out_stall       (out_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding", cycles,
                   expected_splits.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void clear_split_state();
        quote_state = QUOTE_NONE;
        in_argument = 1'b0;
        backslash_run = 0;
        args_opened = 0;
        count_overflow = 1'b0;
    endfunction

    // expected result word for one input word, advancing the predictor state
    function automatic split_result_t split_byte(logic [7:0] c, logic eot);
        split_result_t r;
        int run;
        quote_t kind;
        r = '0;
        if (eot)
        begin
            r.line_done = 1'b1;
            r.parse_error = count_overflow || quote_state != QUOTE_NONE;
            r.arg_total = r.parse_error ? 16'd0 : 16'(args_opened);
            r.backslash_repeat = 16'(backslash_run);
            r.arg_end = in_argument;
            clear_split_state();
            return r;
        end
        // blanks between arguments produce an empty word
        if (!in_argument)
        begin
            if (is_blank(c))
                return r;
            r.arg_begin = 1'b1;
            in_argument = 1'b1;
            if (args_opened >= ARG_LIMIT)
                count_overflow = 1'b1;
            else
                args_opened++;
        end
        // backslashes are only counted here and released with the next byte
        if (c == CH_BSLASH && quote_state != QUOTE_SINGLE)
        begin
            if (backslash_run >= SLASH_LIMIT)
                count_overflow = 1'b1;
            else
                backslash_run++;
            return r;
        end
        run = backslash_run;
        backslash_run = 0;
        r.backslash_repeat = 16'(run);
        // backslashes before a double quote are halved, odd run escapes the quote
        if (c == CH_DQUOTE && run > 0)
        begin
            r.backslash_repeat = 16'(run >> 1);
            if (run % 2 == 1)
            begin
                r.char_out = c;
                r.char_valid = 1'b1;
                return r;
            end
        end
        if (quote_state == QUOTE_NONE && is_blank(c))
        begin
            in_argument = 1'b0;
            r.arg_end = 1'b1;
            return r;
        end
        // quote open and close, the other kind stays literal
        if (c == CH_DQUOTE || c == CH_SQUOTE)
        begin
            kind = (c == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
            if (quote_state == QUOTE_NONE)
            begin
                quote_state = kind;
                return r;
            end
            if (quote_state == kind)
            begin
                quote_state = QUOTE_NONE;
                return r;
            end
        end
        r.char_out = c;
        r.char_valid = 1'b1;
        return r;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] blank_byte();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_BSLASH || b == CH_DQUOTE || b == CH_SQUOTE || is_blank(b));
        return b;
    endfunction

    // offer one word and wait until the splitter takes it
    task automatic send_word(input logic [7:0] ch, input logic eot);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_in <= ch;
        end_of_text <= eot;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        expected_splits.push_back(split_byte(ch, eot));
        words_sent++;
    endtask

    task automatic send_line(input logic [7:0] text[$]);
        foreach (text[i])
            send_word(text[i], 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
        lines_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_splits.size() != 0)
            @(posedge clk);
    endtask

    // field extremes, blank kinds, escaped and grouping quotes, open quote at end
    task automatic test_directed();
        idle_on = 1'b1;
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h0B, 1'b0);
        send_text("\\\\\\\"\\\\\"'\\x\"\f'\\\"'");
        send_word(8'h00, 1'b1);
        send_word(CH_TAB, 1'b0);
        send_text("\"a\\");
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);
        lines_sent += 3;
        wait_drained();
    endtask

    // random lines, mostly built from arguments with quoting and escapes
    task automatic test_random_lines(input int word_goal);
        logic [7:0] text[$];
        logic [7:0] q;
        int start;
        start = words_sent;
        idle_on = 1'b1;
        while (words_sent - start < word_goal)
        begin
            text.delete();
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(0, 12))
                    text.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(0, 4))
                begin
                    repeat ($urandom_range(0, 2))
                        text.push_back(blank_byte());
                    repeat ($urandom_range(1, 4))
                    begin
                        case ($urandom_range(0, 3))
                            0: text.push_back(plain_byte());
                            1:
                            begin
                                repeat ($urandom_range(1, 4))
                                    text.push_back(CH_BSLASH);
                                text.push_back($urandom_range(0, 1) ? CH_DQUOTE : plain_byte());
                            end
                            default:
                            begin
                                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                                text.push_back(q);
                                repeat ($urandom_range(0, 4))
                                begin
                                    case ($urandom_range(0, 3))
                                        0: text.push_back(blank_byte());
                                        1: text.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
                                        2: text.push_back(CH_BSLASH);
                                        default: text.push_back(plain_byte());
                                    endcase
                                end
                                // now and then the quote is left open
                                if ($urandom_range(0, 7) != 0)
                                    text.push_back(q);
                            end
                        endcase
                    end
                    text.push_back(blank_byte());
                end
            end
            send_line(text);
        end
        wait_drained();
    endtask

    // output held off long enough that the input side has to stall
    task automatic test_output_hold();
        logic [7:0] text[$];
        idle_on = 1'b0;
        hold_req = 200;
        for (int i = 0; i < 40; i++)
            text.push_back((i % 5 == 4) ? CH_SPACE : 8'h41 + 8'(i));
        send_line(text);
        wait_drained();
        idle_on = 1'b1;
    endtask

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                if (hold_req > longest_hold)
                    longest_hold = hold_req;
                hold_req = 0;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // result checker against the oldest expectation
    initial
    begin
        split_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_splits.size() == 0)
                begin
                    $error("result word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_splits.pop_front();
                    results_checked++;
                    if (want.line_done && want.parse_error)
                        lines_rejected++;
                    if (backslash_repeat !== want.backslash_repeat)
                    begin
                        $error("backslash_repeat expected %0d got %0d",
                               want.backslash_repeat, backslash_repeat);
                        mismatches++;
                    end
                    if (char_out !== want.char_out)
                    begin
                        $error("char_out expected %h got %h", want.char_out, char_out);
                        mismatches++;
                    end
                    if (char_valid !== want.char_valid)
                    begin
                        $error("char_valid expected %b got %b", want.char_valid, char_valid);
                        mismatches++;
                    end
                    if (arg_begin !== want.arg_begin)
                    begin
                        $error("arg_begin expected %b got %b", want.arg_begin, arg_begin);
                        mismatches++;
                    end
                    if (arg_end !== want.arg_end)
                    begin
                        $error("arg_end expected %b got %b", want.arg_end, arg_end);
                        mismatches++;
                    end
                    if (line_done !== want.line_done)
                    begin
                        $error("line_done expected %b got %b", want.line_done, line_done);
                        mismatches++;
                    end
                    if (parse_error !== want.parse_error)
                    begin
                        $error("parse_error expected %b got %b", want.parse_error, parse_error);
                        mismatches++;
                    end
                    if (arg_total !== want.arg_total)
                    begin
                        $error("arg_total expected %0d got %0d", want.arg_total, arg_total);
                        mismatches++;
                    end
                end
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_output_hold();
        test_random_lines(500);
        test_random_lines(60);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d words in %0d lines, %0d result words checked, %0d lines rejected",
                 words_sent, lines_sent, results_checked, lines_rejected);
        $display("output held up to %0d cycles, input stalled for %0d cycles",
                 longest_hold, input_stall_cycles);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
